### hdl/gbnb_pkg.sv
// Package for the Gaussian blur block: kernel tables, state codes and the
// command/status structs shared by controller and datapath. No dependencies.
`timescale 1ns / 1ps
package gbnb_pkg;

    localparam int MAX_HEIGHT = 1024;

    // Controller state codes
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_WRITE = 3'd1;
    localparam logic [2:0] ST_ACCUM = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_MODE   = 2'd0;
    localparam logic [1:0] CFG_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_HEIGHT = 2'd2;

    // Kernel weights; 3x3 kernel uses row*3+col, 7x7 uses row*7+col
    function automatic logic [6:0] f_k3(input logic [3:0] idx);
        logic [6:0] v;
        unique case (idx)
            4'd4:                     v = 7'd4;
            4'd1, 4'd3, 4'd5, 4'd7:   v = 7'd2;
            default:                  v = 7'd1;
        endcase
        return v;
    endfunction

    function automatic logic [6:0] f_k7(input logic [5:0] idx);
        logic [6:0] v;
        unique case (idx)
            6'd3, 6'd8, 6'd12, 6'd21, 6'd27, 6'd36, 6'd40, 6'd45: v = 7'd5;
            6'd9, 6'd11, 6'd15, 6'd19, 6'd29, 6'd33, 6'd37, 6'd39: v = 7'd18;
            6'd10, 6'd22, 6'd26, 6'd38:                           v = 7'd32;
            6'd16, 6'd18, 6'd30, 6'd32:                           v = 7'd64;
            6'd17, 6'd23, 6'd24, 6'd25, 6'd31:                    v = 7'd100;
            default:                                              v = 7'd0;
        endcase
        return v;
    endfunction

    // Controller to datapath commands
    typedef struct packed {
        logic store;     // write the accepted pixel to the line store
        logic start;     // begin a window pass
        logic step;      // take one window tap
        logic div_start; // load the divider
        logic div_step;  // one quotient bit
        logic load_out;  // move the quotient to the output register
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic emit;      // the item yields a result
        logic tap_last;  // last window tap in flight
        logic div_done;  // quotient complete
        logic out_busy;  // output register holds an item that is not taken this cycle
    } t_status;

endpackage

### hdl/gbnb_ctrl.sv
// Controller state machine for the Gaussian blur block.
// Depends on gbnb_pkg for state codes and command/status structs.
`timescale 1ns / 1ps
module gbnb_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_restart,
    input  gbnb_pkg::t_status i_status,
    output logic              o_in_ready,
    output gbnb_pkg::t_cmd    o_cmd
);
    import gbnb_pkg::*;

    logic [2:0] r_state, n_state;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.store = 1'b1;
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE: begin
                if (i_status.emit) begin
                    o_cmd.start = 1'b1;
                    n_state = ST_ACCUM;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_ACCUM: begin
                o_cmd.step = 1'b1;
                if (i_status.tap_last) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (!i_status.div_done) begin
                    o_cmd.div_step = 1'b1;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!i_status.out_busy) begin
                    o_cmd.load_out = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        if (r_state == ST_ACCUM && i_status.tap_last) begin
            o_cmd.div_start = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // A result pass always runs from start into the accumulation state
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WRITE && i_status.emit && !i_restart) |=> r_state == ST_ACCUM)
        else $error("window pass did not start");
    // Items are taken only in the idle state
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> r_state == ST_IDLE)
        else $error("ready outside idle");
    // The output register is loaded only when free
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> !i_status.out_busy)
        else $error("output overwritten");
endmodule

### hdl/gbnb_dp.sv
// Datapath for the Gaussian blur block: line store, positions, window
// accumulator, serial divider and output register. Depends on gbnb_pkg.
`timescale 1ns / 1ps
module gbnb_dp #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_RADIUS = 3
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_restart,
    input  logic              i_mode,
    input  logic [10:0]       i_width,
    input  logic [10:0]       i_height,
    input  logic [7:0]        i_pixel,
    input  gbnb_pkg::t_cmd    i_cmd,
    output gbnb_pkg::t_status o_status,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [7:0]        o_smoothed,
    output logic              o_last
);
    import gbnb_pkg::*;

    localparam int ROWS  = 3 * MAX_RADIUS + 1;
    localparam int RW    = $clog2(ROWS);
    localparam int DEPTH = ROWS * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = 11;   // positions and sizes up to 2047
    localparam int TW    = 22;   // item counts up to 2047*1024 plus the lead
    localparam int AccW  = 19;   // 255 * 1068 (7x7 weight total) fits
    localparam int WsW   = 11;

    // Effective geometry
    logic [PW-1:0] w_eff, h_eff;
    logic          big;
    logic [1:0]    rad;
    always_comb begin
        w_eff = (i_width == '0) ? PW'(1) : i_width;
        if (32'(i_width) > MAX_WIDTH) w_eff = PW'(MAX_WIDTH);
        h_eff = (i_height == '0) ? PW'(1) : i_height;
        if (i_height > PW'(MAX_HEIGHT)) h_eff = PW'(MAX_HEIGHT);
        big = i_mode && (MAX_RADIUS >= 3);
        rad = big ? 2'd3 : 2'd1;
    end

    // Positions: input col, input row modulo ROWS, output col, row and row modulo ROWS, item count
    logic [PW-1:0] r_in_col, r_out_col, r_out_row;
    logic [RW-1:0] r_in_rm, r_out_rm;
    logic [TW-1:0] r_t;
    logic          r_emit, r_last;

    logic [TW-1:0] frame_items, lead;
    always_comb begin
        frame_items = TW'(w_eff) * TW'(h_eff);
        lead = TW'(rad) * (TW'(w_eff) + TW'(1));
    end

    // Line store
    logic [7:0] mem [DEPTH];
    logic [7:0] r_rd;
    logic [AW-1:0] wr_addr, rd_addr;
    assign wr_addr = AW'(r_in_rm) * AW'(MAX_WIDTH) + AW'(r_in_col);

    // Window tap walker
    logic [2:0]      r_dy, r_dx;       // 0 .. span-1
    logic [RW-1:0]   r_yrm;            // row of tap modulo ROWS
    logic            r_tap_ok, r_tap_v, r_tap_last_d;
    logic [6:0]      r_wt;
    logic [AccW-1:0] r_acc;
    logic [WsW-1:0]  r_wsum;
    logic [2:0]      span_m1;
    logic signed [PW+1:0] y_s, x_s;
    logic            tap_in, tap_end;
    logic [6:0]      wt_now;
    logic [5:0]      k7i;
    logic [3:0]      k3i;

    assign span_m1 = big ? 3'd6 : 3'd2;
    always_comb begin
        y_s = $signed({2'b00, r_out_row}) + $signed({1'b0, r_dy}) - $signed({2'b0, rad});
        x_s = $signed({2'b00, r_out_col}) + $signed({1'b0, r_dx}) - $signed({2'b0, rad});
        tap_in = (y_s >= 0) && (y_s < $signed({2'b00, h_eff}))
              && (x_s >= 0) && (x_s < $signed({2'b00, w_eff}));
        tap_end = (r_dy == span_m1) && (r_dx == span_m1);
        k7i = 6'(r_dy) * 6'd7 + 6'(r_dx);
        k3i = 4'(r_dy) * 4'd3 + 4'(r_dx);
        wt_now = big ? f_k7(k7i) : f_k3(k3i[3:0]);
        rd_addr = AW'(r_yrm) * AW'(MAX_WIDTH) + AW'(x_s[PW-1:0]);
    end

    // Memory write and registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.store && (r_t < frame_items)) begin
            mem[wr_addr] <= i_pixel;
        end
        r_rd <= mem[rd_addr];
    end

    // Position and emit tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_in_col <= '0; r_in_rm <= '0; r_t <= '0;
            r_out_col <= '0; r_out_row <= '0; r_out_rm <= '0;
            r_emit <= 1'b0;
        end else begin
            if (i_cmd.store) begin
                r_emit <= (r_t >= lead);
                r_t <= r_t + TW'(1);
                if (r_in_col + PW'(1) >= w_eff) begin
                    r_in_col <= '0;
                    r_in_rm <= (r_in_rm == RW'(ROWS - 1)) ? '0 : r_in_rm + RW'(1);
                end else begin
                    r_in_col <= r_in_col + PW'(1);
                end
            end
            if (i_cmd.load_out) begin
                if (r_last) begin
                    r_in_col <= '0; r_in_rm <= '0; r_t <= '0;
                    r_out_col <= '0; r_out_row <= '0; r_out_rm <= '0;
                end else if (r_out_col + PW'(1) >= w_eff) begin
                    r_out_col <= '0;
                    r_out_row <= r_out_row + PW'(1);
                    r_out_rm <= (r_out_rm == RW'(ROWS - 1)) ? '0 : r_out_rm + RW'(1);
                end else begin
                    r_out_col <= r_out_col + PW'(1);
                end
            end
        end
    end

    // Tap walk and accumulate; memory read data arrives in the cycle after its address
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_dy <= '0; r_dx <= '0;
            r_yrm <= (r_out_rm >= RW'(rad)) ? r_out_rm - RW'(rad)
                                           : r_out_rm + RW'(ROWS) - RW'(rad);
            r_acc <= '0; r_wsum <= '0; r_tap_v <= 1'b0; r_tap_last_d <= 1'b0;
            r_last <= (r_out_row == h_eff - PW'(1)) && (r_out_col == w_eff - PW'(1));
        end else begin
            r_tap_v <= i_cmd.step && !r_tap_last_d;
            r_tap_ok <= tap_in;
            r_wt <= wt_now;
            if (i_cmd.step && !r_tap_last_d) begin
                r_tap_last_d <= tap_end;
                if (r_dx == span_m1) begin
                    r_dx <= '0;
                    r_dy <= r_dy + 3'd1;
                    r_yrm <= (r_yrm == RW'(ROWS - 1)) ? '0 : r_yrm + RW'(1);
                end else begin
                    r_dx <= r_dx + 3'd1;
                end
            end
            if (r_tap_v && r_tap_ok) begin
                r_acc <= r_acc + AccW'(r_wt * r_rd);
                r_wsum <= r_wsum + WsW'(r_wt);
            end
        end
    end

    // Restoring divider, one quotient bit per cycle. The last tap's product
    // reaches r_acc while div_start passes from r_load_num into r_num_pend, and
    // the numerator is then taken, so quotient steps count only once it is in place.
    logic [AccW-1:0] r_q, r_rem_num;
    logic [WsW:0]    r_rem;
    logic [4:0]      r_cnt;
    logic            r_div_done, r_div_arm;
    logic            r_load_num, r_num_pend;
    logic [WsW+1:0]  trial;
    logic            div_go;
    assign trial = {r_rem, r_rem_num[AccW-1]} - {1'b0, 1'b0, r_wsum};
    assign div_go = i_cmd.div_step && r_div_arm;

    // Numerator capture timing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_load_num <= 1'b0; r_num_pend <= 1'b0;
        end else begin
            r_load_num <= i_cmd.div_start;
            r_num_pend <= r_load_num;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_div_done <= 1'b0; r_div_arm <= 1'b0;
        end else if (i_cmd.div_start || i_cmd.load_out) begin
            r_div_done <= 1'b0; r_div_arm <= 1'b0;
        end else if (r_num_pend) begin
            r_div_arm <= 1'b1;
        end else if (div_go && (r_cnt == 5'(AccW - 1))) begin
            r_div_done <= 1'b1; r_div_arm <= 1'b0;
        end
        if (i_cmd.div_start) begin
            r_cnt <= '0; r_rem <= '0;
        end else if (r_num_pend) begin
            r_rem_num <= r_acc;
        end else if (div_go) begin
            r_cnt <= r_cnt + 5'd1;
            r_rem_num <= {r_rem_num[AccW-2:0], 1'b0};
            if (!trial[WsW+1]) begin
                r_rem <= trial[WsW:0];
                r_q <= {r_q[AccW-2:0], 1'b1};
            end else begin
                r_rem <= {r_rem[WsW-1:0], r_rem_num[AccW-1]};
                r_q <= {r_q[AccW-2:0], 1'b0};
            end
        end
    end

    // Output register
    logic r_ov;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_ov <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_ov <= 1'b1;
        end else if (i_ready) begin
            r_ov <= 1'b0;
        end
        if (i_cmd.load_out) begin
            o_smoothed <= (r_wsum != '0) ? r_q[7:0] : 8'd0;
            o_last <= r_last;
        end
    end
    assign o_valid = r_ov;

    always_comb begin
        o_status.emit = r_emit;
        o_status.tap_last = i_cmd.step && tap_end && !r_tap_last_d;
        o_status.div_done = r_div_done;
        o_status.out_busy = r_ov && !i_ready;
    end

    // Output position never passes the frame
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_row < h_eff || r_out_row == '0)
        else $error("output row out of frame");
    // Divider starts only with a complete tap walk
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_start |-> tap_end)
        else $error("divider started early");
endmodule

### hdl/gaussian_blur_normalized_border_top.sv
// Top level of the Gaussian blur block: configuration registers, controller
// and datapath. Depends on gbnb_pkg, gbnb_ctrl and gbnb_dp.
`timescale 1ns / 1ps
// One input item is taken at a time. A flush or early pixel goes from the
// write state straight back to idle; an item that yields a result walks the
// whole window one tap per cycle through the single line-store read port
// (9 taps for 3x3, 49 for 7x7), waits for the last product and the numerator
// to be registered, then runs the 19-bit bit-serial divider; an item takes
// longer while a held result blocks the output register. The output register
// lets the next item enter while a result waits. After each frame send
// radius*(width+1) padding items to flush the last outputs.
module gaussian_blur_normalized_border_top #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_RADIUS = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // pixel[7:0]
    input  logic        s_axis_tuser,   // is_padding
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // smoothed[7:0]
    output logic        m_axis_tlast,   // last_of_frame
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [10:0] i_cfg_data
);
    import gbnb_pkg::*;

    logic        r_mode;
    logic [10:0] r_width, r_height;
    t_cmd        cmd;
    t_status     status;
    logic        pad_unused;

    // Configuration registers; any write restarts the frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0; r_width <= 11'd1024; r_height <= 11'd1024;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MODE:   r_mode <= i_cfg_data[0];
                CFG_WIDTH:  r_width <= i_cfg_data;
                CFG_HEIGHT: r_height <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    // Padding is inferred from the item count
    assign pad_unused = s_axis_tuser;

    gbnb_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid || (pad_unused && 1'b0)),
        .i_restart(i_cfg_we), .i_status(status),
        .o_in_ready(s_axis_tready), .o_cmd(cmd)
    );

    gbnb_dp #(.MAX_WIDTH(MAX_WIDTH), .MAX_RADIUS(MAX_RADIUS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_restart(i_cfg_we),
        .i_mode(r_mode), .i_width(r_width), .i_height(r_height),
        .i_pixel(s_axis_tdata), .i_cmd(cmd), .o_status(status),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_smoothed(m_axis_tdata), .o_last(m_axis_tlast)
    );
endmodule
